// ===== src/segment_box_clipper_macros.svh =====
// assertion macros for the segment box clipper
// used by segment_box_clipper and sbc_clip, expect clk_i and rst_ni in scope
`ifndef SEGMENT_BOX_CLIPPER_MACROS_SVH
`define SEGMENT_BOX_CLIPPER_MACROS_SVH
`ifndef SYNTH
`define SBC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("sbc assertion failed");
`define SBC_ASSERT_IMP(lbl, pre, post) \
  `SBC_ASSERT(lbl, (pre) |-> (post))
`else
`define SBC_ASSERT(lbl, prop)
`define SBC_ASSERT_IMP(lbl, pre, post)
`endif
`endif

// ===== src/sbc_pkg.sv =====
// shared widths, types and register codes of the segment box clipper
// no dependencies
package sbc_pkg;
  localparam int COORD_W = 30;
  localparam int DIFF_W = COORD_W + 1;
  localparam int MAG_W = COORD_W;
  localparam int T_FRAC_BITS = 24;
  localparam int DIV_BITS = T_FRAC_BITS + 2;
  localparam int T_W = T_FRAC_BITS + 3;
  localparam int PROD_W = T_W + DIFF_W;
  localparam int LATENCY = DIV_BITS + 5;

  localparam logic signed [COORD_W-1:0] LAT_MIN_RST = -30'sd94371840;
  localparam logic signed [COORD_W-1:0] LAT_MAX_RST = 30'sd94371840;
  localparam logic signed [COORD_W-1:0] LON_MIN_RST = -30'sd188743680;
  localparam logic signed [COORD_W-1:0] LON_MAX_RST = 30'sd188743680;

  localparam logic signed [T_W-1:0] T_ONE = T_W'(1) <<< T_FRAC_BITS;
  localparam logic [T_W-1:0] T_LIM = T_W'(1) << (T_FRAC_BITS + 1);

  typedef enum logic [1:0] {
    CFG_LAT_MIN = 2'd0,
    CFG_LAT_MAX = 2'd1,
    CFG_LON_MIN = 2'd2,
    CFG_LON_MAX = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_lat;
    logic signed [COORD_W-1:0] a_lon;
    logic signed [DIFF_W-1:0] d_lat;
    logic signed [DIFF_W-1:0] d_lon;
    logic rej;
  } side_t;
endpackage

// ===== src/sbc_div.sv =====
// pipelined restoring divider, one quotient bit per stage, saturating
// depends on sbc_pkg
module sbc_div (
  input  logic clk_i,
  input  logic [sbc_pkg::MAG_W-1:0] mp_i,
  input  logic [sbc_pkg::MAG_W-1:0] mq_i,
  input  logic sat_i,
  input  logic neg_i,
  output logic signed [sbc_pkg::T_W-1:0] t_o
);
  localparam int NB = sbc_pkg::DIV_BITS;
  localparam int MW = sbc_pkg::MAG_W;

  logic [MW-1:0] rem_q [0:NB];
  logic [MW-1:0] mp_q [0:NB];
  logic [NB-1:0] quo_q [0:NB];
  logic [1:0] nb_q [0:NB];
  logic sat_q [0:NB];
  logic neg_q [0:NB];

  assign rem_q[0] = {2'b00, mq_i[MW-1:2]};
  assign mp_q[0] = mp_i;
  assign quo_q[0] = '0;
  assign nb_q[0] = mq_i[1:0];
  assign sat_q[0] = sat_i;
  assign neg_q[0] = neg_i;

  for (genvar k = 0; k < NB; k++) begin : g_stage
    logic [MW:0] r_sh, diff;
    logic ge;
    assign r_sh = {rem_q[k], nb_q[k][1]};
    assign diff = r_sh - {1'b0, mp_q[k]};
    assign ge = r_sh >= {1'b0, mp_q[k]};
    always_ff @(posedge clk_i) begin
      rem_q[k+1] <= ge ? diff[MW-1:0] : r_sh[MW-1:0];
      mp_q[k+1] <= mp_q[k];
      quo_q[k+1] <= {quo_q[k][NB-2:0], ge};
      nb_q[k+1] <= {nb_q[k][0], 1'b0};
      sat_q[k+1] <= sat_q[k];
      neg_q[k+1] <= neg_q[k];
    end
  end

  logic [sbc_pkg::T_W-1:0] quo_ext, mag;
  assign quo_ext = sbc_pkg::T_W'(quo_q[NB]);
  assign mag = (sat_q[NB] || quo_ext > sbc_pkg::T_LIM) ? sbc_pkg::T_LIM : quo_ext;
  assign t_o = neg_q[NB] ? -$signed(mag) : $signed(mag);
endmodule

// ===== src/sbc_clip.sv =====
// entry/exit selection, products and clipped endpoints, three stages
// depends on sbc_pkg and the macros header
`include "segment_box_clipper_macros.svh"
module sbc_clip (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  input  sbc_pkg::side_t side_i,
  input  logic signed [sbc_pkg::T_W-1:0] t0_i,
  input  logic signed [sbc_pkg::T_W-1:0] t1_i,
  input  logic signed [sbc_pkg::T_W-1:0] t2_i,
  input  logic signed [sbc_pkg::T_W-1:0] t3_i,
  output logic valid_o,
  output logic visible_o,
  output logic signed [sbc_pkg::COORD_W-1:0] clip_start_lat_o,
  output logic signed [sbc_pkg::COORD_W-1:0] clip_start_lon_o,
  output logic signed [sbc_pkg::COORD_W-1:0] clip_end_lat_o,
  output logic signed [sbc_pkg::COORD_W-1:0] clip_end_lon_o
);
  localparam int TW = sbc_pkg::T_W;
  localparam int CW = sbc_pkg::COORD_W;

  logic signed [TW-1:0] lo_lat, hi_lat, lo_lon, hi_lon, lo_d, hi_d, lo1, hi1;

  always_comb begin
    lo_lat = '0;
    hi_lat = sbc_pkg::T_ONE;
    lo_lon = '0;
    hi_lon = sbc_pkg::T_ONE;
    if (side_i.d_lat > 0) begin
      lo_lat = t0_i;
      hi_lat = t1_i;
    end else if (side_i.d_lat < 0) begin
      lo_lat = t1_i;
      hi_lat = t0_i;
    end
    if (side_i.d_lon > 0) begin
      lo_lon = t2_i;
      hi_lon = t3_i;
    end else if (side_i.d_lon < 0) begin
      lo_lon = t3_i;
      hi_lon = t2_i;
    end
    lo1 = (lo_lat > lo_lon) ? lo_lat : lo_lon;
    hi1 = (hi_lat < hi_lon) ? hi_lat : hi_lon;
    lo_d = (lo1 > 0) ? lo1 : '0;
    hi_d = (hi1 < sbc_pkg::T_ONE) ? hi1 : sbc_pkg::T_ONE;
  end

  // stage a: parameters
  logic va_q, ok_q;
  logic signed [TW-1:0] lo_q, hi_q;
  sbc_pkg::side_t sa_q;
  // stage b: products
  logic vb_q, okb_q;
  sbc_pkg::side_t sb_q;
  logic signed [sbc_pkg::PROD_W-1:0] p_slat_q, p_slon_q, p_elat_q, p_elon_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      valid_o <= 1'b0;
    end else begin
      va_q <= valid_i;
      vb_q <= va_q;
      valid_o <= vb_q;
    end
  end

  logic signed [sbc_pkg::PROD_W-1:0] sh_slat, sh_slon, sh_elat, sh_elon;
  assign sh_slat = p_slat_q >>> sbc_pkg::T_FRAC_BITS;
  assign sh_slon = p_slon_q >>> sbc_pkg::T_FRAC_BITS;
  assign sh_elat = p_elat_q >>> sbc_pkg::T_FRAC_BITS;
  assign sh_elon = p_elon_q >>> sbc_pkg::T_FRAC_BITS;

  always_ff @(posedge clk_i) begin
    ok_q <= !side_i.rej && (hi_d >= lo_d);
    lo_q <= lo_d;
    hi_q <= hi_d;
    sa_q <= side_i;
    okb_q <= ok_q;
    sb_q <= sa_q;
    p_slat_q <= lo_q * sa_q.d_lat;
    p_slon_q <= lo_q * sa_q.d_lon;
    p_elat_q <= hi_q * sa_q.d_lat;
    p_elon_q <= hi_q * sa_q.d_lon;
    visible_o <= okb_q;
    clip_start_lat_o <= okb_q ? sb_q.a_lat + sh_slat[CW-1:0] : '0;
    clip_start_lon_o <= okb_q ? sb_q.a_lon + sh_slon[CW-1:0] : '0;
    clip_end_lat_o <= okb_q ? sb_q.a_lat + sh_elat[CW-1:0] : '0;
    clip_end_lon_o <= okb_q ? sb_q.a_lon + sh_elon[CW-1:0] : '0;
  end

  `SBC_ASSERT_IMP(a_ok_order, va_q && ok_q, lo_q <= hi_q)
  `SBC_ASSERT_IMP(a_lo_range, va_q, lo_q >= 0 && hi_q <= sbc_pkg::T_ONE)
  `SBC_ASSERT_IMP(a_vis_follows, valid_o, visible_o == $past(ok_q, 2))
endmodule

// ===== src/segment_box_clipper.sv =====
// top level of the segment box clipper: config registers, p/q front end,
// four sbc_div dividers with a matching delay line, and sbc_clip
//
// channel   dir  handshake                 payload
// item in   in   start_i & !busy_o         start_lat_i start_lon_i end_lat_i end_lon_i
// config    in   cfg_valid_i & cfg_ready_o cfg_index_i cfg_data_i
// result    out  valid_o, one cycle        visible_o clip_*_o
//
// one item per cycle; each result passes the front stages, the 26 quotient stages of the
// divider and the clip stages, in that order.
// busy_o stays low, the pipeline never stalls and the receiver cannot hold results.
// reset clears valid bits and loads the default box.
`include "segment_box_clipper_macros.svh"
module segment_box_clipper (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start_i,
  output logic busy_o,
  input  logic signed [sbc_pkg::COORD_W-1:0] start_lat_i,
  input  logic signed [sbc_pkg::COORD_W-1:0] start_lon_i,
  input  logic signed [sbc_pkg::COORD_W-1:0] end_lat_i,
  input  logic signed [sbc_pkg::COORD_W-1:0] end_lon_i,
  input  logic cfg_valid_i,
  output logic cfg_ready_o,
  input  logic [1:0] cfg_index_i,
  input  logic [sbc_pkg::COORD_W-1:0] cfg_data_i,
  output logic valid_o,
  output logic visible_o,
  output logic signed [sbc_pkg::COORD_W-1:0] clip_start_lat_o,
  output logic signed [sbc_pkg::COORD_W-1:0] clip_start_lon_o,
  output logic signed [sbc_pkg::COORD_W-1:0] clip_end_lat_o,
  output logic signed [sbc_pkg::COORD_W-1:0] clip_end_lon_o
);
  localparam int CW = sbc_pkg::COORD_W;
  localparam int DW = sbc_pkg::DIFF_W;
  localparam int MW = sbc_pkg::MAG_W;
  localparam int NB = sbc_pkg::DIV_BITS;

  assign busy_o = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic signed [CW-1:0] lat_min_q, lat_max_q, lon_min_q, lon_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_min_q <= sbc_pkg::LAT_MIN_RST;
      lat_max_q <= sbc_pkg::LAT_MAX_RST;
      lon_min_q <= sbc_pkg::LON_MIN_RST;
      lon_max_q <= sbc_pkg::LON_MAX_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (sbc_pkg::cfg_idx_e'(cfg_index_i))
        sbc_pkg::CFG_LAT_MIN: lat_min_q <= cfg_data_i;
        sbc_pkg::CFG_LAT_MAX: lat_max_q <= cfg_data_i;
        sbc_pkg::CFG_LON_MIN: lon_min_q <= cfg_data_i;
        sbc_pkg::CFG_LON_MAX: lon_max_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // stage 1: differences and edge distances
  logic v1_q;
  logic signed [CW-1:0] a_lat_q, a_lon_q;
  logic signed [DW-1:0] d_lat_q, d_lon_q, q0_q, q1_q, q2_q, q3_q;

  // stage 2: magnitudes, signs, saturation and parallel reject
  logic v2_q;
  sbc_pkg::side_t s2_q;
  logic [MW-1:0] mp_lat_q, mp_lon_q, mq0_q, mq1_q, mq2_q, mq3_q;
  logic [3:0] sat_q, neg_q;

  logic v_dly_q [1:NB];
  sbc_pkg::side_t side_dly_q [1:NB];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      for (int k = 1; k <= NB; k++) v_dly_q[k] <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
      v2_q <= v1_q;
      v_dly_q[1] <= v2_q;
      for (int k = 2; k <= NB; k++) v_dly_q[k] <= v_dly_q[k-1];
    end
  end

  function automatic logic [MW-1:0] abs_f(logic signed [DW-1:0] x);
    logic signed [DW-1:0] n;
    n = -x;
    return x[DW-1] ? n[MW-1:0] : x[MW-1:0];
  endfunction

  function automatic logic sat_f(logic [MW-1:0] mq, logic [MW-1:0] mp);
    return {2'b00, mq} >= {mp, 2'b00};
  endfunction

  logic [MW-1:0] mp_lat_d, mp_lon_d, mq0_d, mq1_d, mq2_d, mq3_d;
  logic lat_z, lon_z;
  assign mp_lat_d = abs_f(d_lat_q);
  assign mp_lon_d = abs_f(d_lon_q);
  assign mq0_d = abs_f(q0_q);
  assign mq1_d = abs_f(q1_q);
  assign mq2_d = abs_f(q2_q);
  assign mq3_d = abs_f(q3_q);
  assign lat_z = d_lat_q == '0;
  assign lon_z = d_lon_q == '0;

  always_ff @(posedge clk_i) begin
    a_lat_q <= start_lat_i;
    a_lon_q <= start_lon_i;
    d_lat_q <= DW'(end_lat_i) - DW'(start_lat_i);
    d_lon_q <= DW'(end_lon_i) - DW'(start_lon_i);
    q0_q <= DW'(start_lat_i) - DW'(lat_min_q);
    q1_q <= DW'(lat_max_q) - DW'(start_lat_i);
    q2_q <= DW'(start_lon_i) - DW'(lon_min_q);
    q3_q <= DW'(lon_max_q) - DW'(start_lon_i);

    s2_q.a_lat <= a_lat_q;
    s2_q.a_lon <= a_lon_q;
    s2_q.d_lat <= d_lat_q;
    s2_q.d_lon <= d_lon_q;
    s2_q.rej <= (lat_z && (q0_q[DW-1] || q1_q[DW-1])) ||
                (lon_z && (q2_q[DW-1] || q3_q[DW-1]));
    mp_lat_q <= mp_lat_d;
    mp_lon_q <= mp_lon_d;
    mq0_q <= mq0_d;
    mq1_q <= mq1_d;
    mq2_q <= mq2_d;
    mq3_q <= mq3_d;
    sat_q <= {sat_f(mq3_d, mp_lon_d), sat_f(mq2_d, mp_lon_d),
              sat_f(mq1_d, mp_lat_d), sat_f(mq0_d, mp_lat_d)};
    // p0 = -d_lat, p1 = d_lat, p2 = -d_lon, p3 = d_lon
    neg_q <= {q3_q[DW-1] ^ d_lon_q[DW-1], q2_q[DW-1] ^ !d_lon_q[DW-1],
              q1_q[DW-1] ^ d_lat_q[DW-1], q0_q[DW-1] ^ !d_lat_q[DW-1]};

    side_dly_q[1] <= s2_q;
    for (int k = 2; k <= NB; k++) side_dly_q[k] <= side_dly_q[k-1];
  end

  logic signed [sbc_pkg::T_W-1:0] t0, t1, t2, t3;

  sbc_div u_div0 (.clk_i, .mp_i(mp_lat_q), .mq_i(mq0_q), .sat_i(sat_q[0]),
                  .neg_i(neg_q[0]), .t_o(t0));
  sbc_div u_div1 (.clk_i, .mp_i(mp_lat_q), .mq_i(mq1_q), .sat_i(sat_q[1]),
                  .neg_i(neg_q[1]), .t_o(t1));
  sbc_div u_div2 (.clk_i, .mp_i(mp_lon_q), .mq_i(mq2_q), .sat_i(sat_q[2]),
                  .neg_i(neg_q[2]), .t_o(t2));
  sbc_div u_div3 (.clk_i, .mp_i(mp_lon_q), .mq_i(mq3_q), .sat_i(sat_q[3]),
                  .neg_i(neg_q[3]), .t_o(t3));

  sbc_clip u_clip (
    .clk_i,
    .rst_ni,
    .valid_i(v_dly_q[NB]),
    .side_i(side_dly_q[NB]),
    .t0_i(t0),
    .t1_i(t1),
    .t2_i(t2),
    .t3_i(t3),
    .valid_o,
    .visible_o,
    .clip_start_lat_o,
    .clip_start_lon_o,
    .clip_end_lat_o,
    .clip_end_lon_o
  );

  `SBC_ASSERT_IMP(a_item_latency, valid_o, $past(start_i, sbc_pkg::LATENCY))
  `SBC_ASSERT_IMP(a_reject_zero, valid_o && !visible_o,
                  clip_start_lat_o == '0 && clip_start_lon_o == '0 &&
                  clip_end_lat_o == '0 && clip_end_lon_o == '0)
  `SBC_ASSERT(a_never_busy, !busy_o && cfg_ready_o)
endmodule
